[design/cfr_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the command frame receiver.
// No dependencies; every other design file imports this package.
package cfr_pkg;

  localparam int FRAME_LEN   = 12;
  localparam int CRC_LEN     = 10;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [7:0]  SYNC_BYTE0    = 8'hA5;
  localparam logic [7:0]  SYNC_BYTE1    = 8'h5A;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd20;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  localparam logic [7:0] CMD_SHUTTER      = 8'h04;
  localparam logic [7:0] CMD_STOP         = 8'h20;
  localparam logic [7:0] CMD_FWD          = 8'h40;
  localparam logic [7:0] CMD_BACK         = 8'h41;
  localparam logic [7:0] CMD_CONFIG       = 8'h80;
  localparam logic [7:0] CMD_BATCH        = 8'h10;
  localparam logic [7:0] CMD_VARIANT_MASK = 8'h0A;

  localparam logic [31:0] MOVE_VALUE_MAX  = 32'h00FF_FFFF;
  localparam logic [31:0] BATCH_VALUE_MAX = 32'h00FF_FFFE;
  localparam logic [7:0]  BATCH_A_MAX     = 8'd99;
  localparam logic [7:0]  BATCH_B_MAX     = 8'd9;
  localparam logic [7:0]  BATCH_C_MAX     = 8'd99;
  localparam logic [7:0]  CONFIG_A_ALL    = 8'hFF;

  localparam logic [3:0] OUT_SHUTTER     = 4'd0;
  localparam logic [3:0] OUT_STOP        = 4'd1;
  localparam logic [3:0] OUT_FWD         = 4'd2;
  localparam logic [3:0] OUT_BACK        = 4'd3;
  localparam logic [3:0] OUT_CONFIG      = 4'd4;
  localparam logic [3:0] OUT_BATCH       = 4'd5;
  localparam logic [3:0] OUT_SYNC_ERR    = 4'd6;
  localparam logic [3:0] OUT_HEADER_ERR  = 4'd7;
  localparam logic [3:0] OUT_CRC_ERR     = 4'd8;
  localparam logic [3:0] OUT_SHUTTER_ERR = 4'd9;
  localparam logic [3:0] OUT_STOP_ERR    = 4'd10;
  localparam logic [3:0] OUT_MOVE_ERR    = 4'd11;
  localparam logic [3:0] OUT_CONFIG_ERR  = 4'd12;
  localparam logic [3:0] OUT_BATCH_ERR   = 4'd13;
  localparam logic [3:0] OUT_UNKNOWN     = 4'd14;
  localparam logic [3:0] OUT_TIMEOUT     = 4'd15;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [7:0]  command_byte;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [31:0] value_word;
  } result_t;

  typedef enum logic [1:0] {
    EV_SYNC,
    EV_HEADER,
    EV_TIMEOUT,
    EV_FRAME
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic        crc_ok;
    logic [7:0]  command_byte;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [31:0] value_word;
  } event_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/cfr_front.sv]
// Front end: sync hunt, frame assembly, running CRC, idle timeout, timeout register.
// Depends on cfr_pkg; pushes one event per verdict into the event queue.
module cfr_front
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        item_push,
  input  item_t       item,
  input  logic        q_full,
  output logic        ev_push,
  output event_t      ev
);

  localparam int FIRST_KEPT = 2;
  localparam int LAST_KEPT  = FRAME_LEN - 2;

  logic [15:0]    timeout_ticks;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]    crc, crc_next;
  logic [15:0]    idle_count, idle_count_next;
  logic [7:0]     frame [FIRST_KEPT:LAST_KEPT];

  logic        accept;
  logic        store_en;
  logic [15:0] limit;
  logic [15:0] idle_inc;
  logic [7:0]  b;

  assign accept = item_push && !q_full;
  assign b      = item.data_byte;
  assign limit  = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign idle_inc = (idle_count == IDLE_MAX) ? idle_count : idle_count + 16'd1;

  always_comb begin
    pos_next        = pos;
    crc_next        = crc;
    idle_count_next = idle_count;
    store_en        = 1'b0;
    ev_push         = 1'b0;
    ev              = '0;
    ev.kind         = EV_SYNC;
    if (accept) begin
      if (item.op) begin
        if (pos != '0) begin
          if (idle_inc >= limit) begin
            pos_next        = '0;
            crc_next        = CRC_INIT;
            idle_count_next = '0;
            ev_push         = 1'b1;
            ev.kind         = EV_TIMEOUT;
          end else begin
            idle_count_next = idle_inc;
          end
        end
      end else begin
        priority if (pos == '0 && b != SYNC_BYTE0) begin
          ev_push = 1'b1;
          ev.kind = EV_SYNC;
        end else if (pos == POS_W'(1) && b != SYNC_BYTE1) begin
          ev_push = 1'b1;
          ev.kind = EV_HEADER;
          if (b != SYNC_BYTE0) begin
            pos_next        = '0;
            crc_next        = CRC_INIT;
            idle_count_next = '0;
          end
        end else begin
          store_en        = 1'b1;
          idle_count_next = '0;
          if (pos < POS_W'(CRC_LEN)) begin
            crc_next = crc16_byte(crc, b);
          end
          if (pos == POS_W'(FRAME_LEN - 1)) begin
            pos_next          = '0;
            crc_next          = CRC_INIT;
            ev_push           = 1'b1;
            ev.kind           = EV_FRAME;
            ev.crc_ok         = (crc == {b, frame[LAST_KEPT]});
            ev.command_byte   = frame[2];
            ev.arg_a          = frame[3];
            ev.arg_b          = frame[4];
            ev.arg_c          = frame[5];
            ev.value_word     = {frame[6], frame[7], frame[8], frame[9]};
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      pos           <= '0;
      crc           <= CRC_INIT;
      idle_count    <= '0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      pos        <= pos_next;
      crc        <= crc_next;
      idle_count <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = FIRST_KEPT; i <= LAST_KEPT; i++) begin
      if (store_en && pos == POS_W'(i)) begin
        frame[i] <= b;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(FRAME_LEN - 1))
    else $error("frame position out of range");

  a_timeout_restart: assert property (@(posedge clk) disable iff (rst)
    (ev_push && ev.kind == EV_TIMEOUT) |=> (pos == '0 && idle_count == '0 && crc == CRC_INIT))
    else $error("timeout did not return parser to hunt");
`endif

endmodule

[design/cfr_queue.sv]
// Two-entry event queue between the parser front end and the classifier back end.
// Depends on cfr_pkg for event_t and the queue depth.
module cfr_queue
  import cfr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output event_t head
);

  event_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("event queue overfilled");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("event pushed while queue full");
`endif

endmodule

[design/cfr_back.sv]
// Back end: classifies queued events into verdicts and holds the result register.
// Depends on cfr_pkg for event_t, result_t, command codes and outcome codes.
module cfr_back
  import cfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  event_t  q_head,
  output logic    q_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic    out_valid;
  result_t result_q;
  logic    load;
  logic [3:0] outcome;
  logic    args_zero;
  logic    move_ok;
  logic [7:0] cmd_base;

  assign load   = !q_empty && (!out_valid || pop);
  assign q_pop  = load;
  assign empty  = !out_valid;
  assign result = result_q;

  assign args_zero = (q_head.arg_a == 8'd0) && (q_head.arg_b == 8'd0) && (q_head.arg_c == 8'd0);
  assign move_ok   = args_zero && (q_head.value_word <= MOVE_VALUE_MAX);
  assign cmd_base  = q_head.command_byte & ~CMD_VARIANT_MASK;

  always_comb begin
    outcome = OUT_UNKNOWN;
    unique case (q_head.kind)
      EV_SYNC:    outcome = OUT_SYNC_ERR;
      EV_HEADER:  outcome = OUT_HEADER_ERR;
      EV_TIMEOUT: outcome = OUT_TIMEOUT;
      EV_FRAME: begin
        priority if (!q_head.crc_ok) begin
          outcome = OUT_CRC_ERR;
        end else if (q_head.command_byte == CMD_SHUTTER) begin
          outcome = (args_zero && q_head.value_word == 32'd0) ? OUT_SHUTTER : OUT_SHUTTER_ERR;
        end else if (q_head.command_byte == CMD_STOP) begin
          outcome = (args_zero && q_head.value_word == 32'd0) ? OUT_STOP : OUT_STOP_ERR;
        end else if (q_head.command_byte == CMD_FWD) begin
          outcome = move_ok ? OUT_FWD : OUT_MOVE_ERR;
        end else if (q_head.command_byte == CMD_BACK) begin
          outcome = move_ok ? OUT_BACK : OUT_MOVE_ERR;
        end else if (cmd_base == CMD_CONFIG) begin
          outcome = ((q_head.arg_a == 8'd0 || q_head.arg_a == CONFIG_A_ALL)
                     && q_head.arg_b == 8'd0 && q_head.arg_c == 8'd0
                     && q_head.value_word <= MOVE_VALUE_MAX) ? OUT_CONFIG : OUT_CONFIG_ERR;
        end else if (cmd_base == CMD_BATCH) begin
          outcome = (q_head.arg_a <= BATCH_A_MAX
                     && q_head.arg_b >= 8'd1 && q_head.arg_b <= BATCH_B_MAX
                     && q_head.arg_c >= 8'd1 && q_head.arg_c <= BATCH_C_MAX
                     && q_head.value_word <= BATCH_VALUE_MAX) ? OUT_BATCH : OUT_BATCH_ERR;
        end else begin
          outcome = OUT_UNKNOWN;
        end
      end
      default: outcome = OUT_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q.outcome      <= outcome;
      result_q.command_byte <= q_head.command_byte;
      result_q.arg_a        <= q_head.arg_a;
      result_q.arg_b        <= q_head.arg_b;
      result_q.arg_c        <= q_head.arg_c;
      result_q.value_word   <= q_head.value_word;
    end
  end

`ifndef ASSERT_OFF
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(result_q)))
    else $error("waiting result changed before transfer");
`endif

endmodule

[design/command_frame_receiver_unit.sv]
// Top level of the command frame receiver: parser front end, event queue, classifier back end.
// Depends on cfr_pkg, cfr_front, cfr_queue and cfr_back.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   item     | in        | push / full          | item_t   {op, data_byte}
//   result   | out       | pop / empty          | result_t {outcome .. value_word}
//   config   | in        | idle_timeout_we      | idle_timeout_data, 16 bits
//
// One item is taken per cycle while full is low; its verdict, if any, enters the event queue at the
// transfer and moves on to the result register and the ports once that register is empty or popped.
// The front end updates the running CRC a whole byte at a time, combinationally.
// Reset returns the parser to the sync hunt, empties the two-entry event queue
// and the result register, and loads the idle timeout with 20 ticks.
// full rises when the event queue holds two verdicts; a stalled result holds the queue.
module command_frame_receiver_unit
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        idle_timeout_we,
  input  logic [15:0] idle_timeout_data,
  input  logic        push,
  input  item_t       item,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output result_t     result
);

  logic   ev_push;
  event_t ev;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  event_t q_head;

  assign full = q_full;

  cfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (idle_timeout_we),
    .cfg_data  (idle_timeout_data),
    .item_push (push),
    .item      (item),
    .q_full    (q_full),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  cfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  cfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

[test/tb_command_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// Testbench for command_frame_receiver_unit: sync hunt, CRC-16 frame checks, command
// classes and idle timeouts, checked against a cycle-free predictor of the parser.
// Depends on cfr_pkg and the design files; reads nothing else.
module tb_command_frame_receiver_unit;
  import cfr_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        idle_timeout_we = 1'b0;
  logic [15:0] idle_timeout_data = '0;
  logic        push = 1'b0;
  item_t       item = '0;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  result_t     result;

  command_frame_receiver_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .idle_timeout_we   (idle_timeout_we),
    .idle_timeout_data (idle_timeout_data),
    .push              (push),
    .item              (item),
    .full              (full),
    .pop               (pop),
    .empty             (empty),
    .result            (result)
  );

  logic [3:0]  rx_pos = '0;
  logic [7:0]  rx_frame [FRAME_LEN];
  logic [15:0] rx_crc = CRC_INIT;
  logic [15:0] rx_idle = '0;
  logic [15:0] timeout_ticks = TIMEOUT_RESET;

  result_t verdicts_due [$];
  int      errors = 0;
  int      cycles = 0;
  int      items_sent = 0;
  int      stall_left = 0;
  bit      source_gap_on = 1'b1;
  bit      sink_stall_on = 1'b1;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_pause(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_limit();
    return (timeout_ticks == 0) ? 1 : int'(timeout_ticks);
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    return c;
  endfunction

  function automatic void restart_hunt();
    rx_pos  = '0;
    rx_crc  = CRC_INIT;
    rx_idle = '0;
  endfunction

  function automatic void queue_verdict(logic [3:0] outcome, bit with_frame);
    result_t r;
    r = '0;
    r.outcome = outcome;
    if (with_frame) begin
      r.command_byte = rx_frame[2];
      r.arg_a        = rx_frame[3];
      r.arg_b        = rx_frame[4];
      r.arg_c        = rx_frame[5];
      r.value_word   = {rx_frame[6], rx_frame[7], rx_frame[8], rx_frame[9]};
    end
    verdicts_due.push_back(r);
  endfunction

  function automatic logic [3:0] classify_frame();
    logic [7:0]  cmd, a, b, c;
    logic [31:0] v;
    logic        zero_args;
    cmd = rx_frame[2];
    a = rx_frame[3];
    b = rx_frame[4];
    c = rx_frame[5];
    v = {rx_frame[6], rx_frame[7], rx_frame[8], rx_frame[9]};
    zero_args = (a == 0) && (b == 0) && (c == 0);
    if (rx_crc != {rx_frame[11], rx_frame[10]}) return OUT_CRC_ERR;
    if (cmd == CMD_SHUTTER) return (zero_args && v == 0) ? OUT_SHUTTER : OUT_SHUTTER_ERR;
    if (cmd == CMD_STOP) return (zero_args && v == 0) ? OUT_STOP : OUT_STOP_ERR;
    if (cmd == CMD_FWD || cmd == CMD_BACK) begin
      if (!zero_args || v > MOVE_VALUE_MAX) return OUT_MOVE_ERR;
      return (cmd == CMD_FWD) ? OUT_FWD : OUT_BACK;
    end
    if ((cmd & ~CMD_VARIANT_MASK) == CMD_CONFIG) begin
      if ((a != 0 && a != CONFIG_A_ALL) || b != 0 || c != 0 || v > MOVE_VALUE_MAX)
        return OUT_CONFIG_ERR;
      return OUT_CONFIG;
    end
    if ((cmd & ~CMD_VARIANT_MASK) == CMD_BATCH) begin
      if (a > BATCH_A_MAX || b == 0 || b > BATCH_B_MAX || c == 0 || c > BATCH_C_MAX ||
          v > BATCH_VALUE_MAX)
        return OUT_BATCH_ERR;
      return OUT_BATCH;
    end
    return OUT_UNKNOWN;
  endfunction

  function automatic void parse_item(logic is_tick, logic [7:0] b);
    logic [3:0] verdict;
    if (is_tick) begin
      if (rx_pos == 0) return;
      if (rx_idle != IDLE_MAX) rx_idle++;
      if (rx_idle >= eff_limit()) begin
        restart_hunt();
        queue_verdict(OUT_TIMEOUT, 1'b0);
      end
      return;
    end
    if (rx_pos == 0 && b != SYNC_BYTE0) begin
      queue_verdict(OUT_SYNC_ERR, 1'b0);
      return;
    end
    if (rx_pos == 1 && b != SYNC_BYTE1) begin
      if (b != SYNC_BYTE0) restart_hunt();
      queue_verdict(OUT_HEADER_ERR, 1'b0);
      return;
    end
    rx_frame[rx_pos] = b;
    if (rx_pos < CRC_LEN) rx_crc = crc_step(rx_crc, b);
    rx_pos++;
    rx_idle = '0;
    if (rx_pos == FRAME_LEN) begin
      verdict = classify_frame();
      restart_hunt();
      queue_verdict(verdict, 1'b1);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (verdicts_due.size() == 0) begin
      $display("%0t: result with none outstanding, expected none actual %h", $time, got);
      errors++;
      return;
    end
    want = verdicts_due.pop_front();
    compare_field("outcome", want.outcome, got.outcome);
    compare_field("command_byte", want.command_byte, got.command_byte);
    compare_field("arg_a", want.arg_a, got.arg_a);
    compare_field("arg_b", want.arg_b, got.arg_b);
    compare_field("arg_c", want.arg_c, got.arg_c);
    compare_field("value_word", want.value_word, got.value_word);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = draw_pause(sink_stall_on);
      end
    end
  end

  task automatic send_item(input logic is_tick, input logic [7:0] data);
    int gap;
    gap = draw_pause(source_gap_on);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{op: is_tick, data_byte: data};
    @(posedge clk);
    while (full) @(posedge clk);
    if (!(is_tick && rx_pos == 0)) items_sent++;
    parse_item(is_tick, data);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    wait_drained();
    idle_timeout_we   <= 1'b1;
    idle_timeout_data <= ticks;
    @(posedge clk);
    idle_timeout_we <= 1'b0;
    timeout_ticks = ticks;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [31:0] v, input bit bad_crc,
                            input int length, input int tick_pct);
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [15:0] crc;
    frame_bytes = '{SYNC_BYTE0, SYNC_BYTE1, cmd, a, b, c,
                    v[31:24], v[23:16], v[15:8], v[7:0], 8'h00, 8'h00};
    crc = CRC_INIT;
    for (int k = 0; k < CRC_LEN; k++) crc = crc_step(crc, frame_bytes[k]);
    if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
    frame_bytes[10] = crc[7:0];
    frame_bytes[11] = crc[15:8];
    for (int k = 0; k < length; k++) begin
      if (k > 0 && eff_limit() > 1 && $urandom_range(0, 99) < tick_pct)
        send_ticks($urandom_range(1, (eff_limit() > 5) ? 4 : eff_limit() - 1));
      send_item(1'b0, frame_bytes[k]);
    end
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFF;
      3: return BATCH_A_MAX;
      4: return BATCH_A_MAX + 8'd1;
      5: return BATCH_B_MAX;
      6: return BATCH_B_MAX + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h1;
      2: return BATCH_VALUE_MAX;
      3: return MOVE_VALUE_MAX;
      4: return MOVE_VALUE_MAX + 32'd1;
      5: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_frame(input int length);
    logic [7:0]  cmd, a, b, c;
    logic [31:0] v;
    a = '0;
    b = '0;
    c = '0;
    v = '0;
    case ($urandom_range(0, 6))
      0: cmd = CMD_SHUTTER;
      1: cmd = CMD_STOP;
      2: begin
        cmd = CMD_FWD;
        v = $urandom & MOVE_VALUE_MAX;
      end
      3: begin
        cmd = CMD_BACK;
        v = $urandom & MOVE_VALUE_MAX;
      end
      4: begin
        cmd = CMD_CONFIG | (8'($urandom) & CMD_VARIANT_MASK);
        a = $urandom_range(0, 1) ? CONFIG_A_ALL : 8'h00;
        v = $urandom & MOVE_VALUE_MAX;
      end
      5: begin
        cmd = CMD_BATCH | (8'($urandom) & CMD_VARIANT_MASK);
        a = 8'($urandom_range(0, BATCH_A_MAX));
        b = 8'($urandom_range(1, BATCH_B_MAX));
        c = 8'($urandom_range(1, BATCH_C_MAX));
        v = $urandom_range(0, BATCH_VALUE_MAX);
      end
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0: a = edge_byte();
      1: b = edge_byte();
      2: c = edge_byte();
      3: v = edge_value();
      4: cmd = 8'($urandom);
      default: ;
    endcase
    send_frame(cmd, a, b, c, v, $urandom_range(0, 99) < 10, length, 5);
  endtask

  task automatic flush_partial();
    if (rx_pos != 0) send_ticks(eff_limit());
  endtask

  task automatic test_hunt_and_header();
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, SYNC_BYTE0);
    send_item(1'b0, 8'h00);
    send_item(1'b0, SYNC_BYTE0);
    send_frame(CMD_SHUTTER, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_STOP, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 2, 0);
    send_ticks(eff_limit());
  endtask

  task automatic test_command_classes();
    send_frame(CMD_STOP, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_FWD, 8'h00, 8'h00, 8'h00, MOVE_VALUE_MAX, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_BACK, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_CONFIG | CMD_VARIANT_MASK, CONFIG_A_ALL, 8'h00, 8'h00, 32'h0012_3456,
               1'b0, FRAME_LEN, 0);
    send_frame(CMD_BATCH | CMD_VARIANT_MASK, BATCH_A_MAX, BATCH_B_MAX, BATCH_C_MAX,
               BATCH_VALUE_MAX, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_BATCH, 8'h00, 8'h01, 8'h01, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_SHUTTER, 8'h00, 8'h00, 8'h00, 32'h1, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_STOP, 8'h00, 8'h00, 8'h01, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_FWD, 8'h00, 8'h00, 8'h00, MOVE_VALUE_MAX + 32'd1, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_CONFIG, 8'h01, 8'h00, 8'h00, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_BATCH, 8'h00, 8'h00, 8'h01, 32'h0, 1'b0, FRAME_LEN, 0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, FRAME_LEN, 0);
    send_frame(CMD_SHUTTER, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, FRAME_LEN, 0);
  endtask

  task automatic test_timeout_register();
    write_timeout(16'h0000);
    send_item(1'b0, SYNC_BYTE0);
    send_ticks(1);
    write_timeout(16'h0001);
    send_frame(CMD_FWD, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4, 0);
    send_ticks(1);
    write_timeout(16'h0003);
    send_frame(CMD_BACK, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 3, 0);
    send_ticks(2);
    send_item(1'b0, 8'h00);
    send_ticks(3);
    source_gap_on = 1'b0;
    sink_stall_on = 1'b0;
    write_timeout(16'hFFFF);
    send_item(1'b0, SYNC_BYTE0);
    send_ticks(100);
    write_timeout(16'd64);
    send_ticks(1);
    source_gap_on = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int count, input logic [15:0] ticks);
    int first, r;
    write_timeout(ticks);
    first = items_sent;
    while (items_sent - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        flush_partial();
        send_random_frame(FRAME_LEN);
      end else if (r < 80) begin
        flush_partial();
        send_random_frame($urandom_range(1, FRAME_LEN - 1));
      end else if (r < 90) begin
        if ($urandom_range(0, 1)) begin
          send_item(1'b0, 8'($urandom));
        end else begin
          send_item(1'b0, SYNC_BYTE0);
          send_item(1'b0, 8'($urandom));
        end
      end else begin
        send_ticks($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_hunt_and_header();
    test_command_classes();
    test_timeout_register();
    test_random_traffic(500, 16'd5);
    source_gap_on = 1'b0;
    sink_stall_on = 1'b0;
    test_random_traffic(500, 16'($urandom_range(2, 40)));
    source_gap_on = 1'b1;
    sink_stall_on = 1'b1;
    test_random_traffic(500, TIMEOUT_RESET);
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
